[rtl/rwf_pkg.sv]
// Shared constants, types and the sequencer state type of the rolling window
// fingerprint block. No dependencies; others refer to it by scope or import.
package rwf_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
  localparam int WLEN_W     = 7;
  localparam int CMP_W      = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;
  localparam int BYTE_W     = 8;
  localparam int HASH_W     = 61;
  localparam int HALF_W     = 32;
  localparam int ACC_W      = 2 * HASH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 3;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [WLEN_W-1:0]    wlen_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [HASH_W-1:0]    hash_t;
  typedef logic [HASH_W:0]      wide_t;
  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [2*HALF_W-1:0]  prod_t;
  typedef logic [ACC_W-1:0]     acc_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STEP_W-1:0]    step_t;

  // Mersenne modulus 2^61-1
  localparam hash_t MOD_M = {HASH_W{1'b1}};

  localparam wlen_t WLEN_RESET = wlen_t'(16);
  localparam hash_t BASE_RESET = hash_t'(257);

  localparam cfg_idx_t REG_WINDOW_LENGTH = cfg_idx_t'(0);
  localparam cfg_idx_t REG_HASH_BASE     = cfg_idx_t'(1);

  // Multiplier sequencing: four partial-product steps, then the fold step
  localparam step_t MUL_FOLD_STEP = step_t'(4);

  typedef enum logic [3:0] {
    ST_PINIT,
    ST_PCHK,
    ST_PMULW,
    ST_PSQW,
    ST_IDLE,
    ST_READ,
    ST_SUB,
    ST_SUBW,
    ST_HORN,
    ST_HORNW,
    ST_OUT
  } rwf_state_t;

endpackage

[rtl/rwf_channels.sv]
// Channel interfaces of the rolling window fingerprint block: byte stream,
// result stream and configuration writes. Depends on rwf_pkg.
interface rwf_byte_if;
  logic           valid;
  logic           ready;
  rwf_pkg::byte_t data_byte;
  logic           restart;
  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface rwf_result_if;
  logic           valid;
  logic           ready;
  rwf_pkg::hash_t fingerprint;
  logic           window_full;
  modport source (output valid, fingerprint, window_full, input ready);
  modport sink   (input valid, fingerprint, window_full, output ready);
endinterface

interface rwf_cfg_if;
  logic              valid;
  logic              ready;
  rwf_pkg::cfg_idx_t reg_index;
  rwf_pkg::hash_t    write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

[rtl/rwf_mulmod.sv]
// Multi-cycle multiplier modulo 2^61-1: one 32x32 partial product per cycle,
// then a Mersenne fold. Depends on rwf_pkg.
module rwf_mulmod (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rwf_pkg::hash_t a,
  input  rwf_pkg::hash_t b,
  output logic           done,
  output rwf_pkg::hash_t result
);

  logic            busy;
  rwf_pkg::step_t  step;
  rwf_pkg::hash_t  op_a;
  rwf_pkg::hash_t  op_b;
  rwf_pkg::acc_t   acc;
  rwf_pkg::half_t  ma;
  rwf_pkg::half_t  mb;
  rwf_pkg::prod_t  prod;
  rwf_pkg::acc_t   pp;
  rwf_pkg::wide_t  s1;
  rwf_pkg::wide_t  s1r;
  rwf_pkg::wide_t  s2;
  rwf_pkg::wide_t  s2r;
  rwf_pkg::hash_t  folded;

  // step bit 1 picks the high half of a, bit 0 the high half of b
  always_comb begin
    ma   = step[1] ? rwf_pkg::half_t'(op_a[rwf_pkg::HASH_W-1:rwf_pkg::HALF_W])
                   : op_a[rwf_pkg::HALF_W-1:0];
    mb   = step[0] ? rwf_pkg::half_t'(op_b[rwf_pkg::HASH_W-1:rwf_pkg::HALF_W])
                   : op_b[rwf_pkg::HALF_W-1:0];
    prod = rwf_pkg::prod_t'(ma) * rwf_pkg::prod_t'(mb);
    case (step)
      rwf_pkg::step_t'(0): pp = rwf_pkg::acc_t'(prod);
      rwf_pkg::step_t'(1),
      rwf_pkg::step_t'(2): pp = rwf_pkg::acc_t'(prod) << rwf_pkg::HALF_W;
      default:             pp = rwf_pkg::acc_t'(prod) << (2 * rwf_pkg::HALF_W);
    endcase
  end

  // fold high and low 61-bit parts twice, each with a conditional subtract
  always_comb begin
    s1  = {1'b0, acc[rwf_pkg::ACC_W-1:rwf_pkg::HASH_W]}
        + {1'b0, acc[rwf_pkg::HASH_W-1:0]};
    s1r = (s1 >= {1'b0, rwf_pkg::MOD_M}) ? s1 - {1'b0, rwf_pkg::MOD_M} : s1;
    s2  = rwf_pkg::wide_t'(s1r[rwf_pkg::HASH_W]) + {1'b0, s1r[rwf_pkg::HASH_W-1:0]};
    s2r = (s2 >= {1'b0, rwf_pkg::MOD_M}) ? s2 - {1'b0, rwf_pkg::MOD_M} : s2;
    folded = rwf_pkg::hash_t'(s2r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == rwf_pkg::MUL_FOLD_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + rwf_pkg::step_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_a <= a;
      op_b <= b;
      acc  <= '0;
    end else if (busy && step != rwf_pkg::MUL_FOLD_STEP) begin
      acc <= acc + pp;
    end
    if (busy && step == rwf_pkg::MUL_FOLD_STEP) begin
      result <= folded;
    end
  end

endmodule

[rtl/rolling_window_fingerprint.sv]
// Top level of the rolling window fingerprint block: sequencer, byte window
// memory and hash state. Depends on rwf_pkg, rwf_channels and rwf_mulmod.
//
// Karp-Rabin fingerprint modulo 2^61-1 over the last window_length bytes of a
// byte stream, one result transfer per byte transfer, in order. Until the
// window has filled since the last restart the result is the Horner prefix
// hash with window_full low. One item is in work at a time: the time from a
// byte's transfer to its result is set by the shared modular multiplier,
// which forms each product from four 32x32 partial products and one fold
// and is used once per byte while filling and twice when full. A result may
// wait in the output register while the next byte is transferred. After reset
// and after every write to the window length or hash base register the block
// recomputes base^(L-1) by square-and-multiply and takes no byte until that is
// done; register writes are taken whenever reset is low, and writes to those
// two registers also restart the stream. Window lengths of zero or above 64
// saturate into 1..64; a base equal to the modulus acts as 0.
module rolling_window_fingerprint (
  input  logic          clk,
  input  logic          rst,
  rwf_byte_if.sink      stream,
  rwf_result_if.source  result,
  rwf_cfg_if.sink       cfg
);

  // window memory, one byte per slot, read data registered
  rwf_pkg::byte_t window_store [rwf_pkg::WINDOW_MAX];
  rwf_pkg::byte_t mem_rdata;

  rwf_pkg::rwf_state_t state;
  rwf_pkg::rwf_state_t state_next;

  // configuration and stream state
  rwf_pkg::wlen_t window_length;
  rwf_pkg::hash_t base_reg;
  rwf_pkg::hash_t hash_value;
  rwf_pkg::len_t  fill_count;
  rwf_pkg::ptr_t  write_pointer;
  rwf_pkg::hash_t base_power;

  // power computation working registers
  rwf_pkg::len_t  pe;
  rwf_pkg::hash_t pr;
  rwf_pkg::hash_t pb;

  rwf_pkg::byte_t cur_byte;

  logic           res_valid;
  rwf_pkg::hash_t res_fingerprint;
  logic           res_window_full;

  // multiplier hook-up
  logic           mul_start;
  rwf_pkg::hash_t mul_a;
  rwf_pkg::hash_t mul_b;
  logic           mul_done;
  rwf_pkg::hash_t mul_result;

  logic           stream_ready;
  logic           mem_rd;
  logic           mem_wr;

  rwf_pkg::len_t  len;
  rwf_pkg::hash_t base;
  rwf_pkg::ptr_t  wp_eff;
  rwf_pkg::len_t  wp_inc;
  rwf_pkg::ptr_t  wp_next;
  logic           full;
  logic           res_free;
  logic           in_xfer;
  logic           cfg_write;
  logic           cfg_known;
  rwf_pkg::hash_t sub_value;
  rwf_pkg::wide_t hsum;
  rwf_pkg::hash_t horner_value;

  // saturate the window length into 1..WINDOW_MAX
  function automatic rwf_pkg::len_t eff_len(input rwf_pkg::wlen_t wl);
    rwf_pkg::cmp_t w;
    w = rwf_pkg::cmp_t'(wl);
    if (w == '0) return rwf_pkg::len_t'(1);
    if (w > rwf_pkg::cmp_t'(rwf_pkg::WINDOW_MAX)) return rwf_pkg::len_t'(rwf_pkg::WINDOW_MAX);
    return rwf_pkg::len_t'(w);
  endfunction

  assign len  = eff_len(window_length);
  assign base = (base_reg >= rwf_pkg::MOD_M) ? base_reg - rwf_pkg::MOD_M : base_reg;

  // slot of the oldest byte, which is also where the new byte goes
  assign wp_eff  = (rwf_pkg::len_t'(write_pointer) < len) ? write_pointer : '0;
  assign wp_inc  = rwf_pkg::len_t'(wp_eff) + rwf_pkg::len_t'(1);
  assign wp_next = (wp_inc >= len) ? '0 : rwf_pkg::ptr_t'(wp_inc);
  assign full    = (fill_count >= len);

  assign res_free  = !res_valid || result.ready;
  assign in_xfer   = stream.valid && stream_ready;
  assign cfg_write = cfg.valid && cfg.ready;
  assign cfg_known = (cfg.reg_index == rwf_pkg::REG_WINDOW_LENGTH)
                  || (cfg.reg_index == rwf_pkg::REG_HASH_BASE);

  // drop the oldest byte's term: hash - old*base^(L-1), kept in 0..M-1
  assign sub_value = (hash_value >= mul_result) ? hash_value - mul_result
                   : rwf_pkg::MOD_M - (mul_result - hash_value);

  // append the new byte: product + byte with one conditional subtract
  assign hsum = {1'b0, mul_result} + rwf_pkg::wide_t'(cur_byte);
  assign horner_value = (hsum >= {1'b0, rwf_pkg::MOD_M})
                      ? rwf_pkg::hash_t'(hsum - {1'b0, rwf_pkg::MOD_M})
                      : rwf_pkg::hash_t'(hsum);

  assign stream.ready       = stream_ready;
  // no register write is taken while reset is held
  assign cfg.ready          = !rst;
  assign result.valid       = res_valid;
  assign result.fingerprint = res_fingerprint;
  assign result.window_full = res_window_full;

  rwf_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_result)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rwf_pkg::ST_PINIT: state_next = rwf_pkg::ST_PCHK;
      rwf_pkg::ST_PCHK: begin
        if (pe == '0)     state_next = rwf_pkg::ST_IDLE;
        else if (pe[0])   state_next = rwf_pkg::ST_PMULW;
        else              state_next = rwf_pkg::ST_PSQW;
      end
      rwf_pkg::ST_PMULW: if (mul_done) state_next = rwf_pkg::ST_PSQW;
      rwf_pkg::ST_PSQW:  if (mul_done) state_next = rwf_pkg::ST_PCHK;
      rwf_pkg::ST_IDLE:  if (in_xfer)  state_next = rwf_pkg::ST_READ;
      rwf_pkg::ST_READ:  state_next = full ? rwf_pkg::ST_SUB : rwf_pkg::ST_HORN;
      rwf_pkg::ST_SUB:   state_next = rwf_pkg::ST_SUBW;
      rwf_pkg::ST_SUBW:  if (mul_done) state_next = rwf_pkg::ST_HORN;
      rwf_pkg::ST_HORN:  state_next = rwf_pkg::ST_HORNW;
      rwf_pkg::ST_HORNW: if (mul_done) state_next = rwf_pkg::ST_OUT;
      rwf_pkg::ST_OUT:   if (res_free) state_next = rwf_pkg::ST_IDLE;
      default:           state_next = rwf_pkg::ST_IDLE;
    endcase
    // a write to a known register restarts the power computation
    if (cfg_write && cfg_known) state_next = rwf_pkg::ST_PINIT;
  end

  // sequencer outputs
  always_comb begin
    stream_ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = pb;
    mul_b        = pb;
    mem_rd       = 1'b0;
    mem_wr       = 1'b0;
    case (state)
      rwf_pkg::ST_PCHK: begin
        mul_start = (pe != '0);
        mul_a     = pe[0] ? pr : pb;
      end
      rwf_pkg::ST_PMULW: mul_start = mul_done;
      rwf_pkg::ST_IDLE:  stream_ready = 1'b1;
      rwf_pkg::ST_READ:  mem_rd = 1'b1;
      rwf_pkg::ST_SUB: begin
        mul_start = 1'b1;
        mul_a     = rwf_pkg::hash_t'(mem_rdata);
        mul_b     = base_power;
      end
      rwf_pkg::ST_HORN: begin
        mul_start = 1'b1;
        mul_a     = hash_value;
        mul_b     = base;
      end
      rwf_pkg::ST_HORNW: mem_wr = mul_done;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rwf_pkg::ST_PINIT;
      window_length <= rwf_pkg::WLEN_RESET;
      base_reg      <= rwf_pkg::BASE_RESET;
      hash_value    <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_known) begin
        case (cfg.reg_index)
          rwf_pkg::REG_WINDOW_LENGTH: window_length <= cfg.write_data[rwf_pkg::WLEN_W-1:0];
          rwf_pkg::REG_HASH_BASE:     base_reg      <= cfg.write_data;
          default: ;
        endcase
        hash_value    <= '0;
        fill_count    <= '0;
        write_pointer <= '0;
      end else if (in_xfer && stream.restart) begin
        hash_value    <= '0;
        fill_count    <= '0;
        write_pointer <= '0;
      end else if (state == rwf_pkg::ST_SUBW && mul_done) begin
        hash_value <= sub_value;
      end else if (state == rwf_pkg::ST_HORNW && mul_done) begin
        hash_value    <= horner_value;
        write_pointer <= wp_next;
        if (!full) fill_count <= fill_count + rwf_pkg::len_t'(1);
      end
      // hold the result until the sink takes it
      if (state == rwf_pkg::ST_OUT && res_free) res_valid <= 1'b1;
      else if (result.ready)                    res_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) cur_byte <= stream.data_byte;
    case (state)
      rwf_pkg::ST_PINIT: begin
        pe <= len - rwf_pkg::len_t'(1);
        pr <= rwf_pkg::hash_t'(1);
        pb <= base;
      end
      rwf_pkg::ST_PCHK: if (pe == '0) base_power <= pr;
      rwf_pkg::ST_PMULW: if (mul_done) pr <= mul_result;
      rwf_pkg::ST_PSQW: begin
        if (mul_done) begin
          pb <= mul_result;
          pe <= pe >> 1;
        end
      end
      rwf_pkg::ST_OUT: begin
        if (res_free) begin
          res_fingerprint <= hash_value;
          res_window_full <= full;
        end
      end
      default: ;
    endcase
  end

  // window memory: read the oldest byte, later overwrite it with the new one
  always_ff @(posedge clk) begin
    if (mem_wr) window_store[wp_eff] <= cur_byte;
    if (mem_rd) mem_rdata <= window_store[wp_eff];
  end

endmodule

[rtl/rwf_checker.sv]
// Port-level checks for the rolling window fingerprint block, bound to its
// top level. Depends on rwf_pkg and the ports of rolling_window_fingerprint.
module rwf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              res_valid,
  input logic              res_ready,
  input rwf_pkg::hash_t    res_fingerprint,
  input logic              res_window_full,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input rwf_pkg::cfg_idx_t cfg_index
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_fingerprint) && $stable(res_window_full))
    else $error("stalled result changed");

  // one byte in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("byte taken while previous byte in work");

  // a write to a known register starts the power computation, which blocks bytes
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
    (cfg_index == rwf_pkg::REG_WINDOW_LENGTH || cfg_index == rwf_pkg::REG_HASH_BASE)
    |=> !in_ready)
    else $error("byte taken before power recomputed");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_fingerprint != rwf_pkg::MOD_M)
    else $error("fingerprint not reduced");

endmodule

bind rolling_window_fingerprint rwf_checker u_rwf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (stream.valid),
  .in_ready        (stream.ready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_fingerprint (result.fingerprint),
  .res_window_full (result.window_full),
  .cfg_valid       (cfg.valid),
  .cfg_ready       (cfg.ready),
  .cfg_index       (cfg.reg_index)
);

[tb/rwf_fingerprint_checker.sv]
// Checker for the rolling window fingerprint block: watches the byte, result
// and register write channels and predicts every fingerprint transfer.
// Depends on rwf_pkg and the channel interfaces in rwf_channels.
`timescale 1ns / 100ps

module rwf_fingerprint_checker (
  input  logic   clk,
  input  logic   rst,
  rwf_byte_if    stream,
  rwf_result_if  result,
  rwf_cfg_if     cfg,
  output int     fail_count,
  output int     pending,
  output int     results_seen,
  output int     full_seen
);
  import rwf_pkg::*;

  typedef struct packed {
    hash_t fingerprint;
    logic  window_full;
  } fp_result_t;

  wlen_t      len_reg;
  hash_t      base_reg;
  byte_t      window_bytes [WINDOW_MAX];
  int         slot;
  int         taken;
  hash_t      running_hash;
  hash_t      oldest_weight;
  fp_result_t fingerprints_due [$];
  int         bad_count;
  int         got_count;
  int         full_count;

  // Effective window: zero and anything above the store depth saturate
  function automatic int window_span();
    if (len_reg == '0) return 1;
    if (int'(len_reg) > WINDOW_MAX) return WINDOW_MAX;
    return int'(len_reg);
  endfunction

  function automatic hash_t active_base();
    return (base_reg == MOD_M) ? '0 : base_reg;
  endfunction

  // Product modulo 2^61-1: fold the bits above the lower 61 onto them twice
  function automatic hash_t mod_mul(input hash_t a, input hash_t b);
    acc_t  prod;
    wide_t sum;
    prod = acc_t'(a) * acc_t'(b);
    sum  = wide_t'(prod[ACC_W-1:HASH_W]) + wide_t'(prod[HASH_W-1:0]);
    sum  = wide_t'(sum[HASH_W]) + wide_t'(sum[HASH_W-1:0]);
    if (sum >= wide_t'(MOD_M)) sum = sum - wide_t'(MOD_M);
    return sum[HASH_W-1:0];
  endfunction

  function automatic hash_t horner_step(input hash_t h, input hash_t b, input byte_t value);
    wide_t sum;
    sum = wide_t'(mod_mul(h, b)) + wide_t'(value);
    if (sum >= wide_t'(MOD_M)) sum = sum - wide_t'(MOD_M);
    return sum[HASH_W-1:0];
  endfunction

  // Weight of the oldest byte in a full window: base^(L-1)
  function automatic hash_t oldest_byte_weight();
    hash_t w;
    int    k;
    w = hash_t'(1);
    for (k = 1; k < window_span(); k++) w = mod_mul(w, active_base());
    return w;
  endfunction

  task automatic clear_window();
    slot         = 0;
    taken        = 0;
    running_hash = '0;
  endtask

  always @(posedge clk) begin : watch
    fp_result_t want;
    hash_t      drop;
    hash_t      kept;
    int         len;
    if (rst) begin
      len_reg  = WLEN_RESET;
      base_reg = BASE_RESET;
      clear_window();
      oldest_weight = oldest_byte_weight();
      fingerprints_due.delete();
      bad_count  = 0;
      got_count  = 0;
      full_count = 0;
    end else begin
      // Register writes restart the stream; spare indexes change nothing
      if (cfg.valid && cfg.ready &&
          (cfg.reg_index == REG_WINDOW_LENGTH || cfg.reg_index == REG_HASH_BASE)) begin
        if (cfg.reg_index == REG_WINDOW_LENGTH) len_reg = wlen_t'(cfg.write_data);
        else base_reg = cfg.write_data;
        clear_window();
        oldest_weight = oldest_byte_weight();
      end

      if (result.valid && result.ready) begin
        got_count++;
        if (result.window_full) full_count++;
        if (fingerprints_due.size() == 0) begin
          if (bad_count < 10)
            $display("%0t: fingerprint %0h / full %0b with no byte outstanding",
                     $realtime, result.fingerprint, result.window_full);
          bad_count++;
        end else begin
          want = fingerprints_due.pop_front();
          if (result.fingerprint !== want.fingerprint ||
              result.window_full !== want.window_full) begin
            if (bad_count < 10)
              $display("%0t: result %0d: expected fingerprint %0h full %0b, got %0h full %0b",
                       $realtime, got_count, want.fingerprint, want.window_full,
                       result.fingerprint, result.window_full);
            bad_count++;
          end
        end
      end

      if (stream.valid && stream.ready) begin
        len = window_span();
        if (stream.restart) clear_window();
        if (slot >= len) slot = 0;
        if (taken < len) begin
          running_hash = horner_step(running_hash, active_base(), stream.data_byte);
          taken++;
        end else begin
          drop = mod_mul(hash_t'(window_bytes[slot]), oldest_weight);
          kept = (running_hash >= drop) ? running_hash - drop : MOD_M - (drop - running_hash);
          running_hash = horner_step(kept, active_base(), stream.data_byte);
        end
        window_bytes[slot] = stream.data_byte;
        slot++;
        if (slot >= len) slot = 0;
        want.fingerprint = running_hash;
        want.window_full = (taken >= len);
        fingerprints_due.push_back(want);
      end
    end
    pending      <= fingerprints_due.size();
    fail_count   <= bad_count;
    results_seen <= got_count;
    full_seen    <= full_count;
  end

endmodule

[tb/tb_rolling_window_fingerprint.sv]
// Top of the rolling window fingerprint testbench: clock, reset, byte and
// register stimulus, result back-pressure and the verdict.
// Depends on rwf_pkg, rwf_channels, the block and rwf_fingerprint_checker.
`timescale 1ns / 100ps

module tb_rolling_window_fingerprint;
  import rwf_pkg::*;

  // Indexes past the register list: the block must ignore them
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  localparam int BYTE_TARGET   = 1400;
  // Settle time before the verdict, well above the longest byte-to-result time
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rwf_byte_if   stream_ch ();
  rwf_result_if result_ch ();
  rwf_cfg_if    cfg_ch ();

  int fail_count;
  int pending;
  int results_seen;
  int full_seen;
  int bytes_sent;
  int restarts_sent;
  int cfg_writes;
  int phases;
  // Set for whole phases: neither side then inserts idle gaps
  bit no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rolling_window_fingerprint u_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  rwf_fingerprint_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .stream       (stream_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  // Offer one byte after a random gap and hold it until the transfer.
  // Leave valid high on return so a following byte can go back to back.
  task automatic send_byte(input byte_t value, input logic restart);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid     <= 1'b1;
    stream_ch.data_byte <= value;
    stream_ch.restart   <= restart;
    do @(posedge clk); while (!(stream_ch.valid && stream_ch.ready));
    bytes_sent++;
    if (restart) restarts_sent++;
  endtask

  // Drop valid and hold off until every fingerprint owed has been transferred.
  // Wait for a clock edge first so the checker has counted the last byte.
  task automatic drain_results();
    stream_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write a register only once the block has nothing outstanding
  task automatic write_reg(input cfg_idx_t idx, input hash_t value);
    drain_results();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.reg_index  <= idx;
    cfg_ch.write_data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  // Window length word: random junk above the 7-bit field, which must be dropped
  function automatic hash_t length_word(input int code);
    hash_t w;
    w = hash_t'({$urandom, $urandom});
    w[WLEN_W-1:0] = wlen_t'(code);
    return w;
  endfunction

  // Result side: a random stall before each transfer, none in no_idle phases
  initial begin : result_sink
    int stall;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  initial begin : stimulus
    int    phase_len;
    int    len_code;
    int    restart_odds;
    int    k;
    hash_t base_word;
    byte_t value;

    // Initialise every input before the first edge
    stream_ch.valid     <= 1'b0;
    stream_ch.data_byte <= '0;
    stream_ch.restart   <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.reg_index    <= REG_WINDOW_LENGTH;
    cfg_ch.write_data   <= '0;
    no_idle       = 1'b0;
    bytes_sent    = 0;
    restarts_sent = 0;
    cfg_writes    = 0;
    phases        = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Reset settings (window 16, base 257): prefix hashes, byte extremes,
    // a restart on the very first byte and another mid-prefix.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);

    // Window length zero saturates to one: every byte fills the window alone
    write_reg(REG_WINDOW_LENGTH, length_word(0));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);

    // Base equal to the modulus acts as zero: fingerprint is the last byte
    write_reg(REG_WINDOW_LENGTH, length_word(2));
    write_reg(REG_HASH_BASE, MOD_M);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);

    // Largest base: roll a full window of two, then restart while full
    write_reg(REG_HASH_BASE, MOD_M - hash_t'(1));
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);

    // Spare indexes must neither change settings nor restart the stream
    write_reg(REG_SPARE_A, hash_t'({$urandom, $urandom}));
    write_reg(REG_SPARE_B, hash_t'({$urandom, $urandom}));
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);

    // Oversized length saturates to the store depth; smallest and zero base
    write_reg(REG_WINDOW_LENGTH, length_word(127));
    write_reg(REG_HASH_BASE, hash_t'(1));
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    write_reg(REG_HASH_BASE, '0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    drain_results();

    // Random part: phases of long runs that usually fill and roll the window,
    // mostly under fresh settings, some with frequent restarts as noise.
    while (bytes_sent < BYTE_TARGET) begin
      phases++;
      no_idle = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 7))
        0:       len_code = 1;
        1:       len_code = 2;
        2:       len_code = WINDOW_MAX;
        3:       len_code = 0;
        4:       len_code = $urandom_range(WINDOW_MAX + 1, 127);
        default: len_code = $urandom_range(3, WINDOW_MAX - 1);
      endcase
      case ($urandom_range(0, 7))
        0:       base_word = hash_t'(1);
        1:       base_word = MOD_M;
        2:       base_word = MOD_M - hash_t'(1);
        3:       base_word = '0;
        default: base_word = hash_t'({$urandom, $urandom});
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_WINDOW_LENGTH, length_word(len_code));
      if ($urandom_range(0, 1) != 0) write_reg(REG_HASH_BASE, base_word);
      if ($urandom_range(0, 7) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  hash_t'({$urandom, $urandom}));

      restart_odds = ($urandom_range(0, 4) == 0) ? 4 : 64;
      phase_len    = $urandom_range(40, 160);
      for (k = 0; k < phase_len; k++) begin
        case ($urandom_range(0, 9))
          0:       value = 8'h00;
          1:       value = 8'hFF;
          default: value = byte_t'($urandom);
        endcase
        send_byte(value, $urandom_range(1, restart_odds) == 1);
      end
      // Pause the sender until every fingerprint of the phase has come back
      drain_results();
    end

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes (%0d restarts) in %0d random phases, %0d register writes",
             bytes_sent, restarts_sent, phases, cfg_writes);
    $display("Checked %0d fingerprints, %0d of them over a full window",
             results_seen, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Slowest correct run (every byte at its slowest, plus power recomputation
  // after every write) stays well under the limit; allow 2 ms.
  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[rolling_window_fingerprint.f]
rtl/rwf_pkg.sv
rtl/rwf_channels.sv
rtl/rwf_mulmod.sv
rtl/rolling_window_fingerprint.sv
rtl/rwf_checker.sv
tb/rwf_fingerprint_checker.sv
tb/tb_rolling_window_fingerprint.sv
